[rtl/frc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the hash function of the flow record cache.
// Used by frc_ctrl, frc_datapath and flow_record_cache_core; depends on nothing.
package frc_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SLOT_W      = 10;
    localparam int HASH_SHIFT  = 16;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t IDX_LAST = idx_t'(TABLE_DEPTH - 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_MERGED    = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic [63:0] addresses;
        logic [39:0] ports_proto;
        logic [31:0] packets;
        logic [31:0] octets;
        logic [31:0] first;
        logic [31:0] last;
        logic [7:0]  flags;
    } rec_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_step;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic cnt_last;
    } dp_status_t;

    // Home slot: low bits of src ^ dst ^ ((sport ^ dport ^ proto) << 16).
    function automatic idx_t home_slot(
        input logic [31:0] src,
        input logic [31:0] dst,
        input logic [15:0] sport,
        input logic [15:0] dport,
        input logic [7:0]  proto
    );
        logic [15:0] mix;
        logic [31:0] h;
        mix = sport ^ dport ^ {8'h00, proto};
        h   = src ^ dst ^ (32'(mix) << HASH_SHIFT);
        return h[IDX_W-1:0];
    endfunction

endpackage

[rtl/frc_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the flow record cache: clearing pass, table scan and commit.
// Depends on frc_pkg; drives the command struct of frc_datapath.
module frc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  frc_pkg::dp_status_t   stat,
    output frc_pkg::ctl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign cmd.clear_step = (state_reg == S_CLEAR);
    assign cmd.load       = accept;
    assign cmd.scan_step  = (state_reg == S_SCAN);
    assign cmd.commit     = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A request that is accepted always starts a scan.
    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN))
        else $error("accepted request did not start a scan");

    // A result is only committed when the output register can take it.
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("commit while output register is occupied");

    // The drain cycle always follows the last scan read.
    a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && stat.cnt_last |=> (state_reg == S_DRAIN))
        else $error("scan did not end in the drain cycle");

endmodule

[rtl/frc_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the flow record cache: record and valid memories, scan compare,
// free-slot search, merge adders and the output register. Depends on frc_pkg.
module frc_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  frc_pkg::ctl_cmd_t     cmd,
    output frc_pkg::dp_status_t   stat,
    input  logic                  opcode,
    input  logic [31:0]           src_addr,
    input  logic [31:0]           dst_addr,
    input  logic [15:0]           src_port,
    input  logic [15:0]           dst_port,
    input  logic [7:0]            protocol,
    input  logic [31:0]           packets,
    input  logic [31:0]           octets,
    input  logic [31:0]           first_time,
    input  logic [31:0]           last_time,
    input  logic [7:0]            flow_flags,
    output logic [2:0]            status,
    output logic [9:0]            slot_index,
    output logic [31:0]           total_packets,
    output logic [31:0]           total_octets,
    output logic [31:0]           record_last_time,
    output logic [7:0]            record_flags
);

    logic           valid_mem [frc_pkg::TABLE_DEPTH];
    frc_pkg::rec_t  rec_mem   [frc_pkg::TABLE_DEPTH];

    // Control state.
    frc_pkg::idx_t  cnt_reg;
    logic           live_reg;
    logic           found_reg;
    logic           free_hi_found_reg;
    logic           free_lo_found_reg;

    // Request and scan payload.
    logic           op_reg;
    logic [63:0]    addr_key_reg;
    logic [39:0]    pp_key_reg;
    logic [31:0]    pkts_reg;
    logic [31:0]    octs_reg;
    logic [31:0]    first_reg;
    logic [31:0]    last_reg;
    logic [7:0]     flags_reg;
    frc_pkg::idx_t  home_reg;
    frc_pkg::idx_t  cmp_idx_reg;
    logic           vld_q_reg;
    frc_pkg::rec_t  rec_q_reg;
    frc_pkg::idx_t  hit_idx_reg;
    frc_pkg::rec_t  hit_rec_reg;
    frc_pkg::idx_t  free_hi_idx_reg;
    frc_pkg::idx_t  free_lo_idx_reg;

    // Output register.
    frc_pkg::status_t           status_reg;
    logic [frc_pkg::SLOT_W-1:0] slot_reg;
    logic [31:0]                tot_pkts_reg;
    logic [31:0]                tot_octs_reg;
    logic [31:0]                rec_last_reg;
    logic [7:0]                 rec_flags_reg;

    logic           key_match;
    logic           cmp_hit;
    logic           cmp_free;
    logic           clr_we;
    frc_pkg::idx_t  clr_addr;
    frc_pkg::idx_t  probe_idx;
    frc_pkg::rec_t  merged_rec;
    frc_pkg::rec_t  new_rec;
    frc_pkg::status_t res_status;
    frc_pkg::idx_t  res_slot;
    logic           res_has_rec;
    frc_pkg::rec_t  res_rec;
    logic           rec_we;
    logic           set_valid;

    assign stat.cnt_last = (cnt_reg == frc_pkg::IDX_LAST);

    assign key_match = vld_q_reg
                    && (rec_q_reg.addresses == addr_key_reg)
                    && (rec_q_reg.ports_proto == pp_key_reg);
    assign cmp_hit   = live_reg && key_match;
    assign cmp_free  = live_reg && !vld_q_reg;

    // Remove clears every matching slot as the scan passes it.
    assign clr_we   = cmd.clear_step || (cmp_hit && (op_reg == frc_pkg::OP_REMOVE));
    assign clr_addr = cmd.clear_step ? cnt_reg : cmp_idx_reg;

    // Linear probing wraps: first free slot at or above home, else lowest free slot.
    assign probe_idx = free_hi_found_reg ? free_hi_idx_reg : free_lo_idx_reg;

    always_comb
    begin
        merged_rec         = hit_rec_reg;
        merged_rec.packets = hit_rec_reg.packets + pkts_reg;
        merged_rec.octets  = hit_rec_reg.octets + octs_reg;
        merged_rec.last    = last_reg;
        merged_rec.flags   = hit_rec_reg.flags | flags_reg;

        new_rec.addresses   = addr_key_reg;
        new_rec.ports_proto = pp_key_reg;
        new_rec.packets     = pkts_reg;
        new_rec.octets      = octs_reg;
        new_rec.first       = first_reg;
        new_rec.last        = last_reg;
        new_rec.flags       = flags_reg;
    end

    always_comb
    begin
        res_status  = frc_pkg::ST_DROPPED;
        res_slot    = hit_idx_reg;
        res_has_rec = 1'b0;
        res_rec     = hit_rec_reg;
        rec_we      = 1'b0;
        set_valid   = 1'b0;
        if (op_reg == frc_pkg::OP_REMOVE)
        begin
            if (found_reg)
            begin
                res_status  = frc_pkg::ST_REMOVED;
                res_has_rec = 1'b1;
            end
            else
            begin
                res_status = frc_pkg::ST_NOT_FOUND;
            end
        end
        else if (found_reg)
        begin
            res_status  = frc_pkg::ST_MERGED;
            res_has_rec = 1'b1;
            res_rec     = merged_rec;
            rec_we      = 1'b1;
        end
        else if (free_lo_found_reg)
        begin
            res_status  = frc_pkg::ST_NEW;
            res_slot    = probe_idx;
            res_has_rec = 1'b1;
            res_rec     = new_rec;
            rec_we      = 1'b1;
            set_valid   = 1'b1;
        end
    end

    // Valid memory: clearing pass, remove clears and insert sets never coincide.
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            valid_mem[clr_addr] <= 1'b0;
        end
        else if (cmd.commit && set_valid)
        begin
            valid_mem[probe_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && rec_we)
        begin
            rec_mem[res_slot] <= res_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            vld_q_reg   <= valid_mem[cnt_reg];
            rec_q_reg   <= rec_mem[cnt_reg];
            cmp_idx_reg <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg           <= '0;
            live_reg          <= 1'b0;
            found_reg         <= 1'b0;
            free_hi_found_reg <= 1'b0;
            free_lo_found_reg <= 1'b0;
        end
        else
        begin
            live_reg <= cmd.scan_step;
            if (cmd.load)
            begin
                cnt_reg           <= '0;
                found_reg         <= 1'b0;
                free_hi_found_reg <= 1'b0;
                free_lo_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.clear_step || cmd.scan_step)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (cmp_hit)
                begin
                    found_reg <= 1'b1;
                end
                if (cmp_free)
                begin
                    free_lo_found_reg <= 1'b1;
                    if (cmp_idx_reg >= home_reg)
                    begin
                        free_hi_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= opcode;
            addr_key_reg <= {src_addr, dst_addr};
            pp_key_reg   <= {src_port, dst_port, protocol};
            pkts_reg     <= packets;
            octs_reg     <= octets;
            first_reg    <= first_time;
            last_reg     <= last_time;
            flags_reg    <= flow_flags;
            home_reg     <= frc_pkg::home_slot(src_addr, dst_addr, src_port,
                                               dst_port, protocol);
        end
        if (cmp_hit && !found_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_rec_reg <= rec_q_reg;
        end
        if (cmp_free && !free_lo_found_reg)
        begin
            free_lo_idx_reg <= cmp_idx_reg;
        end
        if (cmp_free && !free_hi_found_reg && (cmp_idx_reg >= home_reg))
        begin
            free_hi_idx_reg <= cmp_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= res_status;
            if (res_has_rec)
            begin
                slot_reg      <= frc_pkg::SLOT_W'(res_slot);
                tot_pkts_reg  <= res_rec.packets;
                tot_octs_reg  <= res_rec.octets;
                rec_last_reg  <= res_rec.last;
                rec_flags_reg <= res_rec.flags;
            end
            else
            begin
                slot_reg      <= '0;
                tot_pkts_reg  <= '0;
                tot_octs_reg  <= '0;
                rec_last_reg  <= '0;
                rec_flags_reg <= '0;
            end
        end
    end

    assign status           = status_reg;
    assign slot_index       = slot_reg;
    assign total_packets    = tot_pkts_reg;
    assign total_octets     = tot_octs_reg;
    assign record_last_time = rec_last_reg;
    assign record_flags     = rec_flags_reg;

    // Every scan starts at slot zero.
    a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (cnt_reg == '0))
        else $error("scan does not start at slot zero");

    // A compare result is never pending when the result is committed.
    a_no_compare_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !live_reg)
        else $error("commit while a compare is still in flight");

    // An insert never clears a valid mark.
    a_insert_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg && (op_reg == frc_pkg::OP_INSERT) |-> !clr_we)
        else $error("valid mark cleared during an insert");

endmodule

[rtl/flow_record_cache_core.sv]
`timescale 1ns / 1ps
// Flow record cache: every request scans all TABLE_DEPTH slots, one per cycle, through
// the single read port of the record memory, and a new request is accepted only once
// the previous one has been committed to the output register.
// After reset a clearing pass over all TABLE_DEPTH slots zeroes the valid marks;
// in_stall stays high until it is finished. Depends on frc_pkg, frc_ctrl, frc_datapath.
module flow_record_cache_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  protocol,
    input  logic [31:0] packets,
    input  logic [31:0] octets,
    input  logic [31:0] first_time,
    input  logic [31:0] last_time,
    input  logic [7:0]  flow_flags,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [9:0]  slot_index,
    output logic [31:0] total_packets,
    output logic [31:0] total_octets,
    output logic [31:0] record_last_time,
    output logic [7:0]  record_flags
);

    // The controller sequences the clearing pass, the scan of the table, a drain
    // state for the last registered read, and the commit. The commit writes the
    // record memory (merge or new record) and, for a new record, the valid memory,
    // and loads the output register in the same edge. A finished result may wait in
    // the output register while the next request is accepted and scanned; only the
    // commit of that next request waits for the register to be free.
    frc_pkg::ctl_cmd_t   cmd;
    frc_pkg::dp_status_t stat;

    frc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the table. During the scan it compares each slot with the
    // request key, remembers the lowest matching slot with its record, and tracks the
    // first free slot at or above the home slot as well as the lowest free slot, so
    // that probing wraps around the end of the table without a second pass.
    frc_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .opcode           (opcode),
        .src_addr         (src_addr),
        .dst_addr         (dst_addr),
        .src_port         (src_port),
        .dst_port         (dst_port),
        .protocol         (protocol),
        .packets          (packets),
        .octets           (octets),
        .first_time       (first_time),
        .last_time        (last_time),
        .flow_flags       (flow_flags),
        .status           (status),
        .slot_index       (slot_index),
        .total_packets    (total_packets),
        .total_octets     (total_octets),
        .record_last_time (record_last_time),
        .record_flags     (record_flags)
    );

endmodule

[verif/flow_record_cache_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for flow_record_cache_core: insert, merge and remove requests
// checked against a behavioural model of the flow table. Depends on frc_pkg and the RTL.
module flow_record_cache_core_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 4;
    // One request occupies the block for a full table scan plus its accept, drain and commit states.
    localparam int REQ_LATENCY  = frc_pkg::TABLE_DEPTH + 3;
    // Cycles without any accepted request or result before the run is abandoned.
    // The clearing pass, the receiver hold-off and several scans all fit well inside.
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_REQS  = 553;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 4000;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } flow_key_t;

    typedef struct {
        logic        op;
        flow_key_t   key;
        logic [31:0] pkts;
        logic [31:0] octs;
        logic [31:0] t_first;
        logic [31:0] t_last;
        logic [7:0]  flags;
    } flow_req_t;

    typedef struct {
        frc_pkg::status_t status;
        logic [9:0]       slot;
        logic [31:0]      pkts;
        logic [31:0]      octs;
        logic [31:0]      t_last;
        logic [7:0]       flags;
    } flow_result_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic        opcode     = 1'b0;
    logic [31:0] src_addr   = '0;
    logic [31:0] dst_addr   = '0;
    logic [15:0] src_port   = '0;
    logic [15:0] dst_port   = '0;
    logic [7:0]  protocol   = '0;
    logic [31:0] packets    = '0;
    logic [31:0] octets     = '0;
    logic [31:0] first_time = '0;
    logic [31:0] last_time  = '0;
    logic [7:0]  flow_flags = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  status;
    logic [9:0]  slot_index;
    logic [31:0] total_packets;
    logic [31:0] total_octets;
    logic [31:0] record_last_time;
    logic [7:0]  record_flags;

    // The model's own copy of the flow table. Record fields are only read for valid
    // slots, so they need no reset value.
    logic        cache_valid [frc_pkg::TABLE_DEPTH];
    flow_key_t   cache_key   [frc_pkg::TABLE_DEPTH];
    logic [31:0] cache_pkts  [frc_pkg::TABLE_DEPTH];
    logic [31:0] cache_octs  [frc_pkg::TABLE_DEPTH];
    logic [31:0] cache_first [frc_pkg::TABLE_DEPTH];
    logic [31:0] cache_last  [frc_pkg::TABLE_DEPTH];
    logic [7:0]  cache_flags [frc_pkg::TABLE_DEPTH];

    flow_req_t    flow_requests[$];
    flow_result_t expected_records[$];
    // Keys that the stimulus believes are present in the table; it steers merges and
    // removes towards live flows.
    flow_key_t    live_keys[$];
    flow_req_t    cur_req;

    int requests_total  = 0;
    int requests_taken  = 0;
    int results_seen    = 0;
    int error_count     = 0;
    int quiet_cycles    = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int status_seen [5] = '{default: 0};

    flow_record_cache_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .src_addr         (src_addr),
        .dst_addr         (dst_addr),
        .src_port         (src_port),
        .dst_port         (dst_port),
        .protocol         (protocol),
        .packets          (packets),
        .octets           (octets),
        .first_time       (first_time),
        .last_time        (last_time),
        .flow_flags       (flow_flags),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .slot_index       (slot_index),
        .total_packets    (total_packets),
        .total_octets     (total_octets),
        .record_last_time (record_last_time),
        .record_flags     (record_flags)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------------------
    // Behavioural model of the flow table.
    // ------------------------------------------------------------------------------------

    // Snapshot of one slot as the block reports it.
    function automatic flow_result_t slot_report(input frc_pkg::status_t st, input int s);
        flow_result_t res;
        res.status = st;
        res.slot   = 10'(s);
        res.pkts   = cache_pkts[s];
        res.octs   = cache_octs[s];
        res.t_last = cache_last[s];
        res.flags  = cache_flags[s];
        return res;
    endfunction

    // Applies one request to the model table and returns the result it must produce.
    function automatic flow_result_t apply_flow_request(input flow_req_t r);
        flow_result_t res;
        int           hit;
        int           home;
        int           s;
        logic [31:0]  mix;
        res.status = frc_pkg::ST_DROPPED;
        res.slot   = '0;
        res.pkts   = '0;
        res.octs   = '0;
        res.t_last = '0;
        res.flags  = '0;
        hit = -1;
        // The block scans every slot, so the lowest matching slot wins.
        for (int i = 0; i < frc_pkg::TABLE_DEPTH; i++)
            if (hit < 0 && cache_valid[i] && cache_key[i] == r.key)
                hit = i;

        if (r.op == frc_pkg::OP_REMOVE)
        begin
            if (hit < 0)
            begin
                res.status = frc_pkg::ST_NOT_FOUND;
                return res;
            end
            // The removed record is reported as it stood before it was cleared.
            res = slot_report(frc_pkg::ST_REMOVED, hit);
            for (int i = hit; i < frc_pkg::TABLE_DEPTH; i++)
                if (cache_valid[i] && cache_key[i] == r.key)
                    cache_valid[i] = 1'b0;
            return res;
        end

        if (hit >= 0)
        begin
            cache_pkts[hit]  = cache_pkts[hit] + r.pkts;
            cache_octs[hit]  = cache_octs[hit] + r.octs;
            cache_last[hit]  = r.t_last;
            cache_flags[hit] = cache_flags[hit] | r.flags;
            return slot_report(frc_pkg::ST_MERGED, hit);
        end

        // New flow: home slot from the hash, then linear probing with wrap-around.
        mix  = r.key.src ^ r.key.dst
             ^ ({16'h0000, r.key.sport ^ r.key.dport ^ {8'h00, r.key.proto}} << 16);
        home = int'(mix % 32'(frc_pkg::TABLE_DEPTH));
        for (int k = 0; k < frc_pkg::TABLE_DEPTH; k++)
        begin
            s = (home + k) % frc_pkg::TABLE_DEPTH;
            if (!cache_valid[s])
            begin
                cache_valid[s] = 1'b1;
                cache_key[s]   = r.key;
                cache_pkts[s]  = r.pkts;
                cache_octs[s]  = r.octs;
                cache_first[s] = r.t_first;
                cache_last[s]  = r.t_last;
                cache_flags[s] = r.flags;
                return slot_report(frc_pkg::ST_NEW, s);
            end
        end
        // Every slot is taken: the request is dropped and the table is left alone.
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------------------

    // A clustered key has its home slot among the last eight, which builds probe chains
    // that run off the end of the table and wrap to slot zero.
    function automatic flow_key_t random_key(input bit clustered);
        flow_key_t k;
        k.src   = $urandom;
        k.dst   = $urandom;
        k.sport = 16'($urandom);
        k.dport = 16'($urandom);
        k.proto = 8'($urandom);
        if (clustered)
            k.dst[9:0] = k.src[9:0] ^ (10'h3F8 | 10'($urandom_range(0, 7)));
        return k;
    endfunction

    // Counter and time words, with the extremes turning up often.
    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'h0000_0000;
        if (pick == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic queue_request(input logic op, input flow_key_t k,
                                 input logic [31:0] pkts, input logic [31:0] octs,
                                 input logic [31:0] tf, input logic [31:0] tl,
                                 input logic [7:0] fl);
        flow_req_t r;
        int        idx;
        r.op      = op;
        r.key     = k;
        r.pkts    = pkts;
        r.octs    = octs;
        r.t_first = tf;
        r.t_last  = tl;
        r.flags   = fl;
        flow_requests.push_back(r);
        idx = -1;
        foreach (live_keys[i])
            if (live_keys[i] == k)
                idx = i;
        if (op == frc_pkg::OP_REMOVE)
        begin
            if (idx >= 0)
                live_keys.delete(idx);
        end
        else if (idx < 0 && live_keys.size() < frc_pkg::TABLE_DEPTH)
        begin
            live_keys.push_back(k);
        end
    endtask

    task automatic queue_random(input logic op, input flow_key_t k);
        queue_request(op, k, rand_word(), rand_word(), rand_word(), rand_word(),
                      8'($urandom));
    endtask

    function automatic flow_key_t pick_live_key();
        return live_keys[$urandom_range(0, live_keys.size() - 1)];
    endfunction

    // Idling runs in phases of fifty accepted requests: none, sender only, receiver
    // only, and both lightly.
    function automatic int idle_pct(input bit for_sender);
        int phase;
        phase = (requests_taken / 50) % 4;
        if (phase == 3)
            return 9;
        if (for_sender)
            return (phase == 1) ? 66 : 0;
        return (phase == 2) ? 66 : 0;
    endfunction

    task automatic flag_error(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s: got %0h, expected %0h",
                                 results_seen, name, got, want));
    endtask

    // ------------------------------------------------------------------------------------
    // Request driver. A request is taken at an edge where in_valid is high and in_stall
    // is low; the model is updated at that edge, in the order the block sees requests.
    // While stalled, the request and in_valid are held untouched.
    // ------------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        flow_result_t predicted;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = apply_flow_request(cur_req);
                expected_records.push_back(predicted);
                requests_taken++;
            end
            if (!(in_valid && in_stall))
            begin
                if (flow_requests.size() != 0 &&
                    $urandom_range(0, 99) >= idle_pct(1'b1))
                begin
                    cur_req     = flow_requests.pop_front();
                    in_valid   <= 1'b1;
                    opcode     <= cur_req.op;
                    src_addr   <= cur_req.key.src;
                    dst_addr   <= cur_req.key.dst;
                    src_port   <= cur_req.key.sport;
                    dst_port   <= cur_req.key.dport;
                    protocol   <= cur_req.key.proto;
                    packets    <= cur_req.pkts;
                    octets     <= cur_req.octs;
                    first_time <= cur_req.t_first;
                    last_time  <= cur_req.t_last;
                    flow_flags <= cur_req.flags;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Result monitor and receiver. Every accepted result is checked against the oldest
    // prediction. Once, after HOLD_AT requests, the receiver stalls for a long stretch
    // while the driver keeps offering, so that the block backs up and stalls its input.
    // ------------------------------------------------------------------------------------
    always @(posedge clk)
    begin
        flow_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_records.size() == 0)
                begin
                    flag_error($sformatf("result with no request outstanding: status %0d",
                                         status));
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("status", 32'(status), 32'(want.status));
                    check_field("slot_index", 32'(slot_index), 32'(want.slot));
                    check_field("total_packets", total_packets, want.pkts);
                    check_field("total_octets", total_octets, want.octs);
                    check_field("record_last_time", record_last_time, want.t_last);
                    check_field("record_flags", 32'(record_flags), 32'(want.flags));
                    status_seen[int'(want.status)]++;
                end
                results_seen++;
            end
            if (!hold_done && requests_taken >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < idle_pct(1'b0));
            end
        end
    end

    // Watchdog: abandons the run once quiet_cycles, cleared when either channel moves, hits STALL_LIMIT.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------------------
    initial
    begin
        flow_key_t zero_key;
        flow_key_t ones_key;
        flow_key_t ones_port;
        flow_key_t ones_proto;
        flow_key_t wrap_keys [4];
        int        pick;

        foreach (cache_valid[i])
            cache_valid[i] = 1'b0;

        zero_key         = '0;
        ones_key         = '1;
        ones_port        = '1;
        ones_port.dport  = 16'h0050;
        ones_proto       = '1;
        ones_proto.proto = 8'h06;
        // These keys all hash to the last slot, so the second and later ones have to
        // probe past the end of the table.
        foreach (wrap_keys[i])
        begin
            wrap_keys[i]     = random_key(1'b0);
            wrap_keys[i].dst = wrap_keys[i].src ^ 32'h0000_03FF;
        end

        // Directed part: empty-table remove, extreme keys and counters, counter wrap on
        // merge, flag accumulation, wrap-around probing, reuse of a freed slot, keys that
        // differ only in a port or the protocol, and removes with and without a match.
        queue_request(frc_pkg::OP_REMOVE, zero_key, '0, '0, '0, '0, '0);
        queue_request(frc_pkg::OP_INSERT, zero_key, '0, '0, '0, '0, '0);
        queue_request(frc_pkg::OP_INSERT, ones_key, '1, '1, '1, '1, 8'h01);
        queue_request(frc_pkg::OP_INSERT, ones_key, 32'd2, 32'h10, '0, 32'd1, 8'h80);
        queue_request(frc_pkg::OP_INSERT, ones_key, 32'd5, 32'd7, '1, '1, 8'h7E);
        queue_random(frc_pkg::OP_INSERT, wrap_keys[0]);
        queue_random(frc_pkg::OP_INSERT, wrap_keys[1]);
        queue_random(frc_pkg::OP_INSERT, wrap_keys[2]);
        queue_random(frc_pkg::OP_REMOVE, zero_key);
        queue_random(frc_pkg::OP_INSERT, wrap_keys[3]);
        queue_random(frc_pkg::OP_REMOVE, zero_key);
        queue_random(frc_pkg::OP_REMOVE, wrap_keys[0]);
        queue_random(frc_pkg::OP_INSERT, wrap_keys[2]);
        queue_random(frc_pkg::OP_INSERT, ones_port);
        queue_random(frc_pkg::OP_INSERT, ones_proto);
        queue_random(frc_pkg::OP_REMOVE, ones_key);
        queue_random(frc_pkg::OP_REMOVE, ones_key);
        queue_random(frc_pkg::OP_INSERT, wrap_keys[0]);
        queue_random(frc_pkg::OP_REMOVE, ones_port);
        queue_random(frc_pkg::OP_INSERT, ones_key);

        // Random part: mostly new flows, with merges and removes of live flows and a few
        // removes of flows that were never there.
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55 || live_keys.size() == 0)
                queue_random(frc_pkg::OP_INSERT, random_key($urandom_range(0, 3) == 0));
            else if (pick < 75)
                queue_random(frc_pkg::OP_INSERT, pick_live_key());
            else if (pick < 92)
                queue_random(frc_pkg::OP_REMOVE, pick_live_key());
            else
                queue_random(frc_pkg::OP_REMOVE, random_key(1'b0));
        end

        // Closing part: a few more new flows, a merge and a remove of live flows, and a
        // clustered key that has to probe through the tail of the table.
        repeat (3)
            queue_random(frc_pkg::OP_INSERT, random_key(1'b0));
        if (live_keys.size() != 0)
            queue_random(frc_pkg::OP_INSERT, pick_live_key());
        if (live_keys.size() != 0)
            queue_random(frc_pkg::OP_REMOVE, pick_live_key());
        queue_random(frc_pkg::OP_INSERT, random_key(1'b1));
        queue_random(frc_pkg::OP_INSERT, random_key(1'b0));

        requests_total = flow_requests.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        wait (requests_taken == requests_total);
        while (expected_records.size() != 0)
            @(posedge clk);
        // Allow a further pair of scans for any stray result.
        repeat (2 * REQ_LATENCY) @(posedge clk);

        $display("Run covered %0d requests and %0d results under varied idling.",
                 requests_taken, results_seen);
        $display("Outcomes: %0d new, %0d merged, %0d dropped, %0d removed, %0d not found.",
                 status_seen[frc_pkg::ST_NEW], status_seen[frc_pkg::ST_MERGED],
                 status_seen[frc_pkg::ST_DROPPED], status_seen[frc_pkg::ST_REMOVED],
                 status_seen[frc_pkg::ST_NOT_FOUND]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
